### rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the triangle to trapezoid split block.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  // Coordinate differences need one extra bit; their products twice that.
  localparam int unsigned DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH  = 2 * DIFF_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic [1:0]                    vidx_t;

  localparam vidx_t VIDX_A = 2'd0;
  localparam vidx_t VIDX_B = 2'd1;
  localparam vidx_t VIDX_C = 2'd2;

  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DEGEN,
    KIND_FLAT_TOP,
    KIND_FLAT_BOT,
    KIND_SPLIT
  } kind_e;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
  } tri_t;

  typedef struct packed {
    logic [1:0] piece_count;
    logic       piece_index;
    coord_t     top_y;
    coord_t     bottom_y;
    vidx_t      left_from;
    vidx_t      left_to;
    vidx_t      right_from;
    vidx_t      right_to;
    logic       last;
  } piece_t;

  // Sorted triangle with the differences needed for the left/right test.
  typedef struct packed {
    kind_e  kind;
    vidx_t  v0;
    vidx_t  v1;
    vidx_t  v2;
    coord_t y0;
    coord_t y1;
    coord_t y2;
    diff_t  dx_mid;
    diff_t  dy_bot;
    diff_t  dx_bot;
    diff_t  dy_mid;
  } setup_t;

endpackage

### rtl/core/tts_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_sort
// Orders the vertices by y, classifies the triangle and forms the edge
// differences used by the left/right decision.
// ----------------------------------------------------------------------------
module tts_sort
  import tts_pkg::*;
(
  input  tri_t   tri_i,
  output setup_t setup_o
);

  coord_t xs [3];
  coord_t ys [3];

  assign xs[0] = tri_i.a_x;
  assign xs[1] = tri_i.b_x;
  assign xs[2] = tri_i.c_x;
  assign ys[0] = tri_i.a_y;
  assign ys[1] = tri_i.b_y;
  assign ys[2] = tri_i.c_y;

  always_comb begin
    vidx_t p0;
    vidx_t p1;
    vidx_t p2;
    vidx_t t;
    logic  degen;
    kind_e kind;

    p0 = VIDX_A;
    p1 = VIDX_B;
    p2 = VIDX_C;
    t  = VIDX_A;
    if (ys[p0] > ys[p1]) begin
      t = p0; p0 = p1; p1 = t;
    end
    if (ys[p0] > ys[p2]) begin
      t = p0; p0 = p2; p2 = t;
    end
    if (ys[p1] > ys[p2]) begin
      t = p1; p1 = p2; p2 = t;
    end

    degen = (tri_i.a_y == tri_i.b_y && tri_i.a_y == tri_i.c_y) ||
            (tri_i.a_x == tri_i.b_x && tri_i.a_x == tri_i.c_x);

    // On a flat edge the vertex with the smaller x goes first; ties keep order.
    priority if (degen) begin
      kind = KIND_DEGEN;
    end else if (ys[p0] == ys[p1]) begin
      kind = KIND_FLAT_TOP;
      if (xs[p0] > xs[p1]) begin
        t = p0; p0 = p1; p1 = t;
      end
    end else if (ys[p1] == ys[p2]) begin
      kind = KIND_FLAT_BOT;
      if (xs[p1] > xs[p2]) begin
        t = p1; p1 = p2; p2 = t;
      end
    end else begin
      kind = KIND_SPLIT;
    end

    setup_o.kind   = kind;
    setup_o.v0     = p0;
    setup_o.v1     = p1;
    setup_o.v2     = p2;
    setup_o.y0     = ys[p0];
    setup_o.y1     = ys[p1];
    setup_o.y2     = ys[p2];
    setup_o.dx_mid = diff_t'(xs[p1]) - diff_t'(xs[p0]);
    setup_o.dy_bot = diff_t'(ys[p2]) - diff_t'(ys[p0]);
    setup_o.dx_bot = diff_t'(xs[p2]) - diff_t'(xs[p0]);
    setup_o.dy_mid = diff_t'(ys[p1]) - diff_t'(ys[p0]);
  end

endmodule

### rtl/core/triangle_trapezoid_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_trapezoid_split
// Splits one triangle into zero, one or two trapezoids for scanline fill.
//
// A triangle is taken in any cycle in which the first stage is free, so a new
// triangle can follow in the next cycle. The first stage sorts the vertices
// and forms edge differences; the second stage performs two signed multiplies
// for the exact left/right test and loads a result buffer. The first result
// is presented once the first-stage register has loaded the result buffer.
// A degenerate or flat triangle gives one result and a general triangle
// gives two, so the single result port sets the sustained rate; the next
// triangle waits in the first stage until the last result is taken. Results
// carry the edges as vertex indices (0 = a, 1 = b, 2 = c), upper trapezoid
// first.
// ----------------------------------------------------------------------------
module triangle_trapezoid_split
  import tts_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  tri_t   in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output piece_t out_o
);

  setup_t setup;

  logic   s1_valid_q;
  setup_t s1_q;

  logic   res_valid_q;
  logic   res_two_q;
  logic   res_idx_q;
  piece_t res_first_q;
  piece_t res_second_q;

  logic   res_final;
  logic   res_load_ok;
  logic   s1_take;
  logic   in_fire;
  logic   out_fire;

  logic signed [PROD_WIDTH-1:0] prod_l;
  logic signed [PROD_WIDTH-1:0] prod_r;
  logic                         mid_left;
  piece_t                       first_d;
  piece_t                       second_d;

  tts_sort u_sort (
    .tri_i   (in_i),
    .setup_o (setup)
  );

  assign res_final   = !res_two_q || res_idx_q;
  assign res_load_ok = !res_valid_q || (out_ready_i && res_final);
  assign s1_take     = s1_valid_q && res_load_ok;
  assign in_ready_o  = !s1_valid_q || s1_take;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = res_valid_q && out_ready_i;

  assign out_valid_o = res_valid_q;
  assign out_o       = res_idx_q ? res_second_q : res_first_q;

  // Cross-multiplied slope test: the top-to-middle edge is on the left when
  // its product does not exceed the top-to-bottom one.
  assign prod_l   = PROD_WIDTH'(s1_q.dx_mid) * PROD_WIDTH'(s1_q.dy_bot);
  assign prod_r   = PROD_WIDTH'(s1_q.dx_bot) * PROD_WIDTH'(s1_q.dy_mid);
  assign mid_left = prod_l <= prod_r;

  always_comb begin
    first_d  = '0;
    second_d = '0;
    unique case (s1_q.kind)
      KIND_DEGEN: begin
        first_d.last = 1'b1;
      end
      KIND_FLAT_TOP: begin
        first_d.piece_count = COUNT_ONE;
        first_d.top_y       = s1_q.y0;
        first_d.bottom_y    = s1_q.y2;
        first_d.left_from   = s1_q.v0;
        first_d.left_to     = s1_q.v2;
        first_d.right_from  = s1_q.v1;
        first_d.right_to    = s1_q.v2;
        first_d.last        = 1'b1;
      end
      KIND_FLAT_BOT: begin
        first_d.piece_count = COUNT_ONE;
        first_d.top_y       = s1_q.y0;
        first_d.bottom_y    = s1_q.y2;
        first_d.left_from   = s1_q.v0;
        first_d.left_to     = s1_q.v1;
        first_d.right_from  = s1_q.v0;
        first_d.right_to    = s1_q.v2;
        first_d.last        = 1'b1;
      end
      KIND_SPLIT: begin
        first_d.piece_count  = COUNT_TWO;
        first_d.top_y        = s1_q.y0;
        first_d.bottom_y     = s1_q.y1;
        second_d.piece_count = COUNT_TWO;
        second_d.piece_index = 1'b1;
        second_d.top_y       = s1_q.y1;
        second_d.bottom_y    = s1_q.y2;
        second_d.last        = 1'b1;
        if (mid_left) begin
          first_d.left_from   = s1_q.v0;
          first_d.left_to     = s1_q.v1;
          first_d.right_from  = s1_q.v0;
          first_d.right_to    = s1_q.v2;
          second_d.left_from  = s1_q.v1;
          second_d.left_to    = s1_q.v2;
          second_d.right_from = s1_q.v0;
          second_d.right_to   = s1_q.v2;
        end else begin
          first_d.left_from   = s1_q.v0;
          first_d.left_to     = s1_q.v2;
          first_d.right_from  = s1_q.v0;
          first_d.right_to    = s1_q.v1;
          second_d.left_from  = s1_q.v0;
          second_d.left_to    = s1_q.v2;
          second_d.right_from = s1_q.v1;
          second_d.right_to   = s1_q.v2;
        end
      end
      default: begin
        first_d.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire || (s1_valid_q && !s1_take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= setup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_two_q   <= 1'b0;
      res_idx_q   <= 1'b0;
    end else if (s1_take) begin
      res_valid_q <= 1'b1;
      res_two_q   <= (s1_q.kind == KIND_SPLIT);
      res_idx_q   <= 1'b0;
    end else if (out_fire) begin
      if (res_final) begin
        res_valid_q <= 1'b0;
      end else begin
        res_idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      res_first_q  <= first_d;
      res_second_q <= second_d;
    end
  end

endmodule
